@@ sv/bounded_integer_deque_unit_macros.svh @@
// Assertion helpers for the deque unit checker.
// Both expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BOUNDED_INTEGER_DEQUE_UNIT_MACROS_SVH
`define BOUNDED_INTEGER_DEQUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define BIDU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BIDU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bidu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bidu_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int AT_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT_AT  = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_CONTAINS   = 3'd6,
        OP_CLEAR      = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT
    } t_state;

    // What every cell does in the update cycle.
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_OPEN,
        CM_CLOSE
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode              mode;
        logic [CNT_W-1:0]        at;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    typedef struct packed {
        logic                     en;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         count;
    } t_cmp;

endpackage

`default_nettype wire

@@ sv/bidu_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bidu_cmd_if;
    import bidu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

`default_nettype wire

@@ sv/bidu_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bidu_rsp_if;
    import bidu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic                     found;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         count;

    modport source (output valid, output status, output found, output front_value,
                    output back_value, output count, input ready);
    modport sink   (input valid, input status, input found, input front_value,
                    input back_value, input count, output ready);
endinterface

`default_nettype wire

@@ sv/bounded_integer_deque_unit.sv @@
// A result passes the compare on the accept edge, the update of the cell row and the
//   front/back readout into the response register, in that order.
// A new command is taken only once the last one has passed the compare/shift sequence of the cell row;
//   the wait grows only while a finished result waits on the response side.
// Reset (synchronous, active low): sequence empty, no result pending; cell contents undefined.
`timescale 1ns / 1ps
`default_nettype none

module bounded_integer_deque_unit import bidu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bidu_cmd_if.sink  i_cmd,
    bidu_rsp_if.source o_rsp
);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state                   r_state;
    t_state                   n_state;
    t_op                      r_op;
    logic signed [DATA_W-1:0] r_value;
    logic [POS_W-1:0]         r_pos;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    t_status                  r_status;
    t_status                  n_status;
    logic                     r_found;
    logic                     n_found;

    // response register (parts the row from the consumer)
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic                     r_out_found;
    logic signed [DATA_W-1:0] r_out_front;
    logic signed [DATA_W-1:0] r_out_back;
    logic [CNT_W-1:0]         r_out_count;

    // FSM outputs
    logic w_cmd_ready;
    logic w_exec;
    logic w_load_out;

    // cell row
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]      w_match;
    logic [CAPACITY-1:0]      w_close_sel;
    logic                     w_any_match;
    t_cell_ctl                w_ctl;
    t_cmp                     w_cmp;
    logic                     w_cmd_xfer;

    logic [CNT_W-1:0]         w_ins_at;
    logic signed [DATA_W-1:0] w_front;
    logic signed [DATA_W-1:0] w_back;
    logic [CNT_W-1:0]         w_last;

    assign w_cmd_xfer = i_cmd.valid && w_cmd_ready;

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_cmd.valid) n_state = S_EXEC;
            S_EXEC:   n_state = S_REPORT;
            S_REPORT: if (!r_out_valid || o_rsp.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // FSM: outputs
    always_comb begin
        w_cmd_ready = 1'b0;
        w_exec      = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE:   w_cmd_ready = 1'b1;
            S_EXEC:   w_exec = 1'b1;
            S_REPORT: w_load_out = !r_out_valid || o_rsp.ready;
            default:  w_cmd_ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Compare broadcast: each cell checks the value on the accept edge,
    // so the match bits are registered when the update cycle starts.
    // ------------------------------------------------------------------
    assign w_cmp.en    = w_cmd_xfer;
    assign w_cmp.value = i_cmd.value;
    assign w_cmp.count = r_count;

    assign w_any_match = |w_match;

    // Insert point clamps to the count (append when at or past it).
    assign w_ins_at = (AT_W'(r_pos) >= AT_W'(r_count)) ? r_count : CNT_W'(r_pos);

    // ------------------------------------------------------------------
    // Update cycle: decide status, count and what the row does.
    // Close mask is every slot at or above the first match:
    // m | -m sets all bits from the lowest set bit upward.
    // ------------------------------------------------------------------
    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_found     = 1'b0;
        w_ctl.mode  = CM_HOLD;
        w_ctl.at    = '0;
        w_ctl.value = r_value;
        w_close_sel = '0;
        case (r_op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.mode = CM_OPEN;
                    n_count    = r_count + CNT_W'(1);
                    case (r_op)
                        OP_PUSH_FRONT: w_ctl.at = '0;
                        OP_PUSH_BACK:  w_ctl.at = r_count;
                        default:       w_ctl.at = w_ins_at;
                    endcase
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    if (r_op == OP_POP_FRONT) begin
                        w_ctl.mode  = CM_CLOSE;
                        w_close_sel = '1;
                    end
                end
            end
            OP_REMOVE, OP_CONTAINS: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_any_match) begin
                    n_found = 1'b1;
                    if (r_op == OP_REMOVE) begin
                        w_ctl.mode  = CM_CLOSE;
                        w_close_sel = w_match | (~w_match + CAPACITY'(1));
                        n_count     = r_count - CNT_W'(1);
                    end
                end else begin
                    n_status = ST_MISSING;
                end
            end
            default: n_count = '0;  // clear
        endcase
        if (!w_exec) begin
            w_ctl.mode = CM_HOLD;
        end
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;  // slot beyond the end becomes unused
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        bidu_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_cmp        (w_cmp),
            .i_ctl        (w_ctl),
            .i_close_sel  (w_close_sel[g]),
            .i_from_left  (w_left),
            .i_from_right (w_right),
            .o_data       (w_data[g]),
            .o_match      (w_match[g])
        );
    end

    // ------------------------------------------------------------------
    // Readout after the update: front is slot 0, back is slot count-1.
    // ------------------------------------------------------------------
    assign w_last = r_count - CNT_W'(1);

    always_comb begin
        w_back = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CNT_W'(k) == w_last) begin
                w_back = w_data[k];
            end
        end
        if (r_count == '0) begin
            w_back = '0;
        end
    end

    assign w_front = (r_count == '0) ? '0 : w_data[0];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_count <= n_count;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_cmd_xfer) begin
            r_op    <= t_op'(i_cmd.op);
            r_value <= i_cmd.value;
            r_pos   <= i_cmd.position;
        end
        if (w_exec) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_front  <= w_front;
            r_out_back   <= w_back;
            r_out_count  <= r_count;
        end
    end

    assign i_cmd.ready       = w_cmd_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.back_value  = r_out_back;
    assign o_rsp.count       = r_out_count;

endmodule

`default_nettype wire

@@ sv/bidu_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sequence. Opens a gap by taking from the left neighbor,
// closes one by taking from the right neighbor.
module bidu_cell import bidu_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic [IDX_W-1:0]         i_index,
    input  wire t_cmp                     i_cmp,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic                     i_close_sel,
    input  wire logic signed [DATA_W-1:0] i_from_left,
    input  wire logic signed [DATA_W-1:0] i_from_right,
    output logic signed [DATA_W-1:0]      o_data,
    output logic                          o_match
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_match;
    logic                     n_match;
    logic [CNT_W-1:0]         w_index;

    assign w_index = CNT_W'(i_index);

    always_comb begin
        n_data = r_data;
        case (i_ctl.mode)
            CM_OPEN: begin
                if (w_index == i_ctl.at) begin
                    n_data = i_ctl.value;
                end else if (w_index > i_ctl.at) begin
                    n_data = i_from_left;
                end
            end
            CM_CLOSE: begin
                if (i_close_sel) begin
                    n_data = i_from_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    // only occupied slots may match
    always_comb begin
        n_match = r_match;
        if (i_cmp.en) begin
            n_match = (w_index < i_cmp.count) && (r_data == i_cmp.value);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

`default_nettype wire

@@ sv/bidu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_integer_deque_unit_macros.svh"

module bidu_checker import bidu_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_cmd_valid,
    input wire logic                     i_cmd_ready,
    input wire logic                     i_rsp_valid,
    input wire logic                     i_rsp_ready,
    input wire logic [STAT_W-1:0]        i_rsp_status,
    input wire logic                     i_rsp_found,
    input wire logic signed [DATA_W-1:0] i_rsp_front,
    input wire logic signed [DATA_W-1:0] i_rsp_back,
    input wire logic [CNT_W-1:0]         i_rsp_count
);

    `BIDU_ASSERT_NOW(a_count_bound, i_rsp_valid, i_rsp_count <= CNT_W'(CAPACITY), "count beyond capacity")

    `BIDU_ASSERT_NOW(a_found_ok, i_rsp_valid && i_rsp_found, i_rsp_status == ST_OK, "found with bad status")

    `BIDU_ASSERT_NOW(a_empty_zero, i_rsp_valid && (i_rsp_count == '0), (i_rsp_front == '0) && (i_rsp_back == '0), "empty result shows values")

    // one command in flight at a time
    `BIDU_ASSERT_NEXT(a_one_in_flight, i_cmd_valid && i_cmd_ready, !i_cmd_ready, "second command taken while busy")

    `BIDU_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_count) && $stable(i_rsp_front), "stalled response changed")

endmodule

bind bounded_integer_deque_unit bidu_checker u_bidu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_found  (o_rsp.found),
    .i_rsp_front  (o_rsp.front_value),
    .i_rsp_back   (o_rsp.back_value),
    .i_rsp_count  (o_rsp.count)
);

`default_nettype wire

@@ tb/sv/tb_bounded_integer_deque_unit.sv @@
`timescale 1ns / 1ps

// Deque unit bench: a directed sweep of corner cases, then ~1140 random
// commands under three sender/receiver idle mixes and one long receiver
// hold-off. Every response is scored against its pinned value or an in-bench deque model.
module tb_bounded_integer_deque_unit;
    import bidu_pkg::*;

    // Cycles without any transaction on either side before the run is abandoned.
    // The longest legitimate quiet stretch is the receiver hold-off (HOLD_CYCLES).
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 380;
    localparam int MAX_REPORTED = 10;

    // One response as the model predicts it.
    typedef struct packed {
        t_status                  status;
        logic                     found;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
        logic [CNT_W-1:0]         count;
    } deque_report_t;

    // Directed stimulus row; a fixed response is used only when pinned is set.
    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        logic                     pinned;
        deque_report_t            want;
    } directed_row_t;

    // Random traffic flavors: grow toward full, shrink toward empty, or anything.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_SCATTER
    } traffic_mix_t;

    localparam deque_report_t EMPTY_REFUSED = '{ST_EMPTY, 1'b0, '0, '0, '0};
    localparam deque_report_t EMPTIED_OK    = '{ST_OK, 1'b0, '0, '0, '0};
    localparam deque_report_t FROM_MODEL    = '0;

    // Directed sweep. Sequence contents are noted after some of the commands.
    localparam directed_row_t DIRECTED_ROWS [22] = '{
        // empty sequence: every pop, remove and lookup is refused
        '{OP_POP_FRONT, 32'sd0, 7'd0, 1'b1, EMPTY_REFUSED},
        '{OP_POP_BACK,  32'sd0, 7'd0, 1'b1, EMPTY_REFUSED},
        '{OP_REMOVE,    32'sd5, 7'd0, 1'b1, EMPTY_REFUSED},
        '{OP_CONTAINS,  32'sd5, 7'd0, 1'b1, EMPTY_REFUSED},
        // a single entry popped empties the sequence
        '{OP_PUSH_BACK, 32'h7FFF_FFFF, 7'd0, 1'b1,
          '{ST_OK, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd1}},
        '{OP_POP_FRONT, 32'sd0, 7'd0, 1'b1, EMPTIED_OK},
        // value extremes at both ends: {min}, {min, max}
        '{OP_PUSH_FRONT, 32'h8000_0000, 7'd0, 1'b1,
          '{ST_OK, 1'b0, 32'h8000_0000, 32'h8000_0000, 7'd1}},
        '{OP_PUSH_BACK, 32'h7FFF_FFFF, 7'd0, 1'b1,
          '{ST_OK, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 7'd2}},
        // insert at the front, then past the count (append): {7, min, max, -1}
        '{OP_INSERT_AT, 32'sd7, 7'd0, 1'b1,
          '{ST_OK, 1'b0, 32'sd7, 32'h7FFF_FFFF, 7'd3}},
        '{OP_INSERT_AT, -32'sd1, 7'd64, 1'b1,
          '{ST_OK, 1'b0, 32'sd7, -32'sd1, 7'd4}},
        // mid insert and a duplicate: {7, min, 3, max, -1, 7}
        '{OP_INSERT_AT, 32'sd3, 7'd2, 1'b0, FROM_MODEL},
        '{OP_PUSH_BACK, 32'sd7, 7'd0, 1'b0, FROM_MODEL},
        '{OP_CONTAINS,  32'sd7, 7'd0, 1'b0, FROM_MODEL},
        '{OP_CONTAINS,  32'sd12345, 7'd0, 1'b0, FROM_MODEL},
        // only the frontmost 7 goes
        '{OP_REMOVE,    32'sd7, 7'd0, 1'b0, FROM_MODEL},
        '{OP_REMOVE,    32'sd99, 7'd0, 1'b0, FROM_MODEL},
        '{OP_POP_BACK,  32'sd0, 7'd0, 1'b0, FROM_MODEL},
        '{OP_INSERT_AT, 32'h5555_AAAA, 7'd1, 1'b0, FROM_MODEL},
        // clear, also when already empty
        '{OP_CLEAR,     32'sd0, 7'd0, 1'b1, EMPTIED_OK},
        '{OP_CLEAR,     -32'sd1, 7'd127, 1'b1, EMPTIED_OK},
        // insert on empty with a position past the count appends
        '{OP_INSERT_AT, 32'sd42, 7'd5, 1'b1, '{ST_OK, 1'b0, 32'sd42, 32'sd42, 7'd1}},
        '{OP_REMOVE,    32'sd42, 7'd0, 1'b1, '{ST_OK, 1'b1, '0, '0, '0}}
    };

    logic i_clk;
    logic i_rst_n;

    bidu_cmd_if cmd_bus ();
    bidu_rsp_if rsp_bus ();

    bounded_integer_deque_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    // Model state: index 0 is the front.
    logic signed [DATA_W-1:0] model_entries [$];
    deque_report_t            awaited_reports [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    int n_commands;
    int n_reports;
    int n_full;
    int n_empty;
    int n_missing;
    int n_found;
    int peak_fill;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the model and return the response it should produce.
    function automatic deque_report_t advance_deque_model(t_op op,
                                                          logic signed [DATA_W-1:0] v,
                                                          logic [POS_W-1:0] pos);
        deque_report_t r;
        int hit;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
                if (model_entries.size() >= CAPACITY)
                    r.status = ST_FULL;
                else if (op == OP_PUSH_FRONT)
                    model_entries.push_front(v);
                else if (op == OP_PUSH_BACK || int'(pos) >= model_entries.size())
                    model_entries.push_back(v);
                else
                    model_entries.insert(int'(pos), v);
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (model_entries.size() == 0)
                    r.status = ST_EMPTY;
                else if (op == OP_POP_FRONT)
                    void'(model_entries.pop_front());
                else
                    void'(model_entries.pop_back());
            end
            OP_REMOVE, OP_CONTAINS: begin
                if (model_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = model_entries.size() - 1; i >= 0; i--)
                        if (model_entries[i] == v) hit = i;
                    if (hit < 0) begin
                        r.status = ST_MISSING;
                    end else begin
                        r.found = 1'b1;
                        if (op == OP_REMOVE) model_entries.delete(hit);
                    end
                end
            end
            default: model_entries.delete();
        endcase
        if (model_entries.size() != 0) begin
            r.front = model_entries[0];
            r.back  = model_entries[model_entries.size() - 1];
        end
        r.count = CNT_W'(model_entries.size());
        return r;
    endfunction

    // A large share of values already stored (so lookups hit), plus a small pool
    // near zero for duplicates, the signed extremes, and full-range noise.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        int near_zero;
        sel = $urandom_range(99);
        near_zero = int'($urandom_range(8)) - 4;
        if (sel < 40 && model_entries.size() != 0)
            return model_entries[$urandom_range(model_entries.size() - 1)];
        if (sel < 65) return near_zero;
        if (sel < 75) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one command transaction, wait for it to be taken, then predict.
    task automatic send_command(t_op op, logic signed [DATA_W-1:0] v,
                                logic [POS_W-1:0] pos, logic pinned,
                                deque_report_t pinned_report);
        deque_report_t r;
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.op       <= op;
        cmd_bus.value    <= v;
        cmd_bus.position <= pos;
        do @(posedge i_clk); while (!cmd_bus.ready);

        r = advance_deque_model(op, v, pos);
        n_commands++;
        if (r.status == ST_FULL)    n_full++;
        if (r.status == ST_EMPTY)   n_empty++;
        if (r.status == ST_MISSING) n_missing++;
        if (r.found)                n_found++;
        if (int'(r.count) > peak_fill) peak_fill = int'(r.count);
        awaited_reports.push_back(pinned ? pinned_report : r);
    endtask

    // Random traffic in runs of one flavor; fill runs are long enough to
    // reach capacity and hit refused pushes, drain runs to hit empty.
    task automatic run_random(int n_items);
        traffic_mix_t mix;
        int run_left;
        int pick;
        t_op op;
        logic [POS_W-1:0] pos;
        run_left = 0;
        mix = MIX_SCATTER;
        for (int n = 0; n < n_items; n++) begin
            if (run_left == 0) begin
                mix = traffic_mix_t'($urandom_range(2));
                run_left = (mix == MIX_FILL) ? $urandom_range(140, 90) : $urandom_range(90, 20);
            end
            run_left--;
            pick = $urandom_range(99);
            case (mix)
                MIX_FILL: begin
                    if (pick < 35)      op = OP_PUSH_BACK;
                    else if (pick < 55) op = OP_PUSH_FRONT;
                    else if (pick < 80) op = OP_INSERT_AT;
                    else if (pick < 88) op = OP_CONTAINS;
                    else if (pick < 94) op = OP_REMOVE;
                    else if (pick < 97) op = OP_POP_FRONT;
                    else                op = OP_POP_BACK;
                end
                MIX_DRAIN: begin
                    if (pick < 25)      op = OP_POP_FRONT;
                    else if (pick < 50) op = OP_POP_BACK;
                    else if (pick < 75) op = OP_REMOVE;
                    else if (pick < 85) op = OP_CONTAINS;
                    else if (pick < 92) op = OP_PUSH_BACK;
                    else if (pick < 96) op = OP_INSERT_AT;
                    else                op = OP_PUSH_FRONT;
                end
                default: begin
                    // clear kept rare so the sequence still gets deep
                    if (pick < 3) op = OP_CLEAR;
                    else          op = t_op'($urandom_range(6));
                end
            endcase
            if ($urandom_range(99) < 60)
                pos = POS_W'($urandom_range(model_entries.size()));
            else
                pos = POS_W'($urandom_range(64));
            send_command(op, pick_value(), pos, 1'b0, FROM_MODEL);
        end
    endtask

    // Response side: score each accepted transaction, then choose next ready.
    // A hold-off request from the stimulus is counted down here.
    always @(posedge i_clk) begin : rsp_scoreboard
        deque_report_t want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                n_reports++;
                if (awaited_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("[%0t] unexpected response: status %0d count %0d",
                                 $realtime, rsp_bus.status, rsp_bus.count);
                end else begin
                    want = awaited_reports.pop_front();
                    if (rsp_bus.status !== want.status || rsp_bus.found !== want.found ||
                        rsp_bus.front_value !== want.front ||
                        rsp_bus.back_value !== want.back || rsp_bus.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTED)
                            $display({"[%0t] response %0d: expected st %0d fnd %0d front %0d ",
                                      "back %0d cnt %0d, got st %0d fnd %0d front %0d ",
                                      "back %0d cnt %0d"},
                                     $realtime, n_reports, want.status, want.found,
                                     want.front, want.back, want.count, rsp_bus.status,
                                     rsp_bus.found, rsp_bus.front_value,
                                     rsp_bus.back_value, rsp_bus.count);
                    end
                end
            end

            if (hold_left != 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (hold_request != 0) begin
                hold_left = hold_request - 1;
                hold_request = 0;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: any transaction on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles, %0d responses outstanding",
                     $realtime, quiet_cycles, awaited_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.op       = '0;
        cmd_bus.value    = '0;
        cmd_bus.position = '0;
        rsp_bus.ready    = 1'b0;
        tx_idle_pct      = 34;
        rx_idle_pct      = 64;
        hold_request     = 0;
        hold_left        = 0;
        quiet_cycles     = 0;
        mismatches       = 0;
        n_commands       = 0;
        n_reports        = 0;
        n_full           = 0;
        n_empty          = 0;
        n_missing        = 0;
        n_found          = 0;
        peak_fill        = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // busy sender, stalling receiver
        foreach (DIRECTED_ROWS[k])
            send_command(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].value,
                         DIRECTED_ROWS[k].position, DIRECTED_ROWS[k].pinned,
                         DIRECTED_ROWS[k].want);
        run_random(PHASE_ITEMS);

        // sparse sender idling often, receiver mostly ready
        tx_idle_pct = 64;
        rx_idle_pct = 34;
        run_random(PHASE_ITEMS);

        // back to back; receiver first holds off long enough to back up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = HOLD_CYCLES;
        run_random(PHASE_ITEMS);
        cmd_bus.valid <= 1'b0;

        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d commands, scored %0d responses; peak fill %0d of %0d.",
                 n_commands, n_reports, peak_fill, CAPACITY);
        $display("Refused: %0d full, %0d empty; lookups %0d matched, %0d missed.",
                 n_full, n_empty, n_found, n_missing);
        if (mismatches == 0 && awaited_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
